FILE: sv/broadcast_transaction_table_top_assert.svh
// Assertion macros shared by the broadcast transaction table RTL.
// Each macro expands to one labeled concurrent assertion, disabled while the reset is high.
`ifndef BROADCAST_TRANSACTION_TABLE_TOP_ASSERT_SVH
`define BROADCAST_TRANSACTION_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("broadcast table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BBT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("broadcast table assertion failed");

`endif

FILE: sv/bbt_pkg.sv
// Package for the broadcast transaction table: sizes, codes and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bbt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int KIND_W   = 2;
   localparam int SRC_W    = 16;
   localparam int SEQ_W    = 8;
   localparam int EIDX_W   = 6;
   localparam int STATUS_W = 3;
   localparam int RIDX_W   = 6;
   localparam int RCNT_W   = 7;
   localparam int BYTE_W   = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CREATE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RETRY  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CREATED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RETRANSMIT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NONE       = 3'd6;

   localparam logic CSR_DELIVERY_TICKS = 1'b0;
   localparam logic CSR_MAX_RETRIES    = 1'b1;

   localparam logic [BYTE_W-1:0] DELIVERY_TICKS_RESET = 8'd10;
   localparam logic [BYTE_W-1:0] MAX_RETRIES_RESET    = 8'd2;

   typedef enum logic [2:0] {
      OP_FIND,
      OP_CREATE,
      OP_TICK,
      OP_RETRY,
      OP_IGNORE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [SRC_W-1:0]   src;
      logic [SEQ_W-1:0]   seq;
      logic [IDX_W-1:0]   idx;
      logic               relayed;
      logic               lost;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_SINGLE
   } back_state_type;

endpackage

FILE: sv/bbt_front.sv
// Front end of the broadcast transaction table: takes a request word and
// classifies it into a command for the queue. Depends on bbt_pkg.
`timescale 1ns / 1ps

module bbt_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [bbt_pkg::KIND_W-1:0]  req_kind,
   input  logic [bbt_pkg::SRC_W-1:0]   req_source_address,
   input  logic [bbt_pkg::SEQ_W-1:0]   req_sequence_number,
   input  logic [bbt_pkg::EIDX_W-1:0]  req_entry_index,
   input  logic                        req_all_relayed,
   input  logic                        req_frame_lost,
   input  logic                        queue_full,
   output logic                        push_valid,
   output bbt_pkg::cmd_type            push_cmd
);
   import bbt_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   cmd_type decoded;
   logic    accept;
   logic    in_range;

   // A retry aimed beyond the table is turned into a no-op here.
   assign in_range = ({1'b0, req_entry_index} < (EIDX_W + 1)'(TABLE_ENTRIES));

   always_comb begin
      decoded.src     = req_source_address;
      decoded.seq     = req_sequence_number;
      decoded.idx     = req_entry_index[IDX_W-1:0];
      decoded.relayed = req_all_relayed;
      decoded.lost    = req_frame_lost;
      unique case (req_kind)
         KIND_FIND:   decoded.op = OP_FIND;
         KIND_CREATE: decoded.op = OP_CREATE;
         KIND_TICK:   decoded.op = OP_TICK;
         KIND_RETRY:  decoded.op = in_range ? OP_RETRY : OP_IGNORE;
         default:     decoded.op = OP_IGNORE;
      endcase
   end

   assign busy       = valid_ff && queue_full;
   assign accept     = start && !busy;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      valid_in = accept || (valid_ff && queue_full);
      cmd_in   = accept ? decoded : cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

FILE: sv/bbt_queue.sv
// Short command queue between the front and back of the broadcast table.
// Depends on bbt_pkg for the command type and depth.
`timescale 1ns / 1ps

module bbt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bbt_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output bbt_pkg::cmd_type pop_cmd
);
   import bbt_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/bbt_back.sv
// Back end of the broadcast table: holds the records and carries out each
// command, scanning one record per cycle. Depends on bbt_pkg and the assert macros.
`timescale 1ns / 1ps
`include "broadcast_transaction_table_top_assert.svh"

module bbt_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_empty,
   input  bbt_pkg::cmd_type              queue_cmd,
   output logic                          pop,
   input  logic [bbt_pkg::BYTE_W-1:0]    delivery_ticks,
   input  logic [bbt_pkg::BYTE_W-1:0]    max_retries,
   output logic                          rsp_strobe,
   output logic [bbt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bbt_pkg::RIDX_W-1:0]    rsp_result_index,
   output logic [bbt_pkg::RCNT_W-1:0]    rsp_records_in_use
);
   import bbt_pkg::*;

   back_state_type state_ff, state_in;
   cmd_type        cur_ff, cur_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [TABLE_ENTRIES-1:0] used_ff;
   logic [TABLE_ENTRIES-1:0] pend_ff;
   logic [SRC_W-1:0]  src_ff  [TABLE_ENTRIES];
   logic [SEQ_W-1:0]  seq_ff  [TABLE_ENTRIES];
   logic [BYTE_W-1:0] life_ff [TABLE_ENTRIES];
   logic [BYTE_W-1:0] retr_ff [TABLE_ENTRIES];

   logic                strobe_ff, strobe_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    where_ff, where_in;
   logic [CNT_W-1:0]    shown_ff, shown_in;

   logic [IDX_W-1:0]  addr;
   logic              rd_used, rd_pend;
   logic [BYTE_W-1:0] rd_life, rd_retr;
   logic              last, done;
   logic              used_set, used_clr, pend_set, pend_clr, key_we;
   logic              life_we, retr_we;
   logic [BYTE_W-1:0] life_wd, retr_wd;

   // A single read and write address: the scan counter, or the retry's target.
   assign addr    = (state_ff == BK_SINGLE) ? cur_ff.idx : scan_ff;
   assign rd_used = used_ff[addr];
   assign rd_pend = pend_ff[addr];
   assign rd_life = life_ff[addr];
   assign rd_retr = retr_ff[addr];
   assign last    = (scan_ff == IDX_W'(TABLE_ENTRIES - 1));

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      scan_in   = scan_ff;
      count_in  = count_ff;
      pop       = 1'b0;
      done      = 1'b0;
      status_in = ST_NONE;
      where_in  = '0;
      used_set  = 1'b0;
      used_clr  = 1'b0;
      pend_set  = 1'b0;
      pend_clr  = 1'b0;
      key_we    = 1'b0;
      life_we   = 1'b0;
      life_wd   = rd_life;
      retr_we   = 1'b0;
      retr_wd   = rd_retr;

      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               cur_in  = queue_cmd;
               scan_in = '0;
               if (queue_cmd.op == OP_RETRY || queue_cmd.op == OP_IGNORE) begin
                  state_in = BK_SINGLE;
               end else begin
                  state_in = BK_SCAN;
               end
            end
         end
         BK_SCAN: begin
            unique case (cur_ff.op)
               OP_FIND: begin
                  if (rd_used && src_ff[addr] == cur_ff.src && seq_ff[addr] == cur_ff.seq) begin
                     done      = 1'b1;
                     status_in = ST_HIT;
                     where_in  = scan_ff;
                  end else if (last) begin
                     done      = 1'b1;
                     status_in = ST_MISS;
                  end
               end
               OP_CREATE: begin
                  if (!rd_used) begin
                     used_set  = 1'b1;
                     pend_set  = 1'b1;
                     key_we    = 1'b1;
                     life_we   = 1'b1;
                     life_wd   = delivery_ticks;
                     retr_we   = 1'b1;
                     retr_wd   = '0;
                     count_in  = count_ff + 1'b1;
                     done      = 1'b1;
                     status_in = ST_CREATED;
                     where_in  = scan_ff;
                  end else if (last) begin
                     done      = 1'b1;
                     status_in = ST_FULL;
                  end
               end
               OP_TICK: begin
                  if (rd_used) begin
                     life_we = 1'b1;
                     life_wd = (rd_life == '0) ? '0 : rd_life - 1'b1;
                     // An expired record goes only once its transmission is over.
                     if (life_wd == '0 && !rd_pend) begin
                        used_clr = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  done = last;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               state_in = BK_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         BK_SINGLE: begin
            done     = 1'b1;
            state_in = BK_IDLE;
            if (cur_ff.op == OP_RETRY && rd_used) begin
               if (!rd_pend) begin
                  status_in = ST_RELEASED;
               end else begin
                  retr_we = 1'b1;
                  retr_wd = rd_retr + 1'b1;
                  if (retr_wd >= max_retries || cur_ff.relayed || cur_ff.lost) begin
                     pend_clr  = 1'b1;
                     status_in = ST_RELEASED;
                  end else begin
                     status_in = ST_RETRANSMIT;
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      strobe_in = done;
      shown_in  = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         count_ff  <= '0;
         used_ff   <= '0;
         pend_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         if (used_set) begin
            used_ff[addr] <= 1'b1;
         end
         if (used_clr) begin
            used_ff[addr] <= 1'b0;
         end
         if (pend_set) begin
            pend_ff[addr] <= 1'b1;
         end
         if (pend_clr) begin
            pend_ff[addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      where_ff  <= where_in;
      shown_ff  <= shown_in;
      if (key_we) begin
         src_ff[addr] <= cur_ff.src;
         seq_ff[addr] <= cur_ff.seq;
      end
      if (life_we) begin
         life_ff[addr] <= life_wd;
      end
      if (retr_we) begin
         retr_ff[addr] <= retr_wd;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_result_index   = RIDX_W'(where_ff);
   assign rsp_records_in_use = RCNT_W'(shown_ff);

   `BBT_ASSERT_NEXT(a_one_word_per_command, clock, reset, strobe_ff, !strobe_ff)
   `BBT_ASSERT_SAME(a_count_matches_used, clock, reset, 1'b1,
                    count_ff == CNT_W'($countones(used_ff)))
   `BBT_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1,
                    count_ff <= CNT_W'(TABLE_ENTRIES))
   `BBT_ASSERT_SAME(a_scan_ops_only, clock, reset, state_ff == BK_SCAN,
                    cur_ff.op == OP_FIND || cur_ff.op == OP_CREATE || cur_ff.op == OP_TICK)

endmodule

FILE: sv/broadcast_transaction_table_top.sv
// Top level of the broadcast transaction table: register port, front end,
// command queue and back end. Depends on bbt_pkg, bbt_front, bbt_queue, bbt_back.
//
//   channel   handshake                     word
//   request   start in, busy out            kind, key, index, relay flags
//   result    rsp_strobe out, one cycle     status, record index, count
//   config    psel/penable/pwrite, pready   delivery_ticks, max_retries
//
// A find or create leaves the queue, then scans records from the first until a match
// or a free record, or to the last; a tick always scans every record. A retry or
// an out-of-range retry is handled without a scan. The result shows in the cycle
// after the back end finishes. The back end's one record per cycle sets the pace.
// Reset is synchronous and clears every record at once. The front keeps taking
// words until the queue and its own stage are full; the receiver never stalls.
`timescale 1ns / 1ps

module broadcast_transaction_table_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bbt_pkg::KIND_W-1:0]      req_kind,
   input  logic [bbt_pkg::SRC_W-1:0]       req_source_address,
   input  logic [bbt_pkg::SEQ_W-1:0]       req_sequence_number,
   input  logic [bbt_pkg::EIDX_W-1:0]      req_entry_index,
   input  logic                            req_all_relayed,
   input  logic                            req_frame_lost,
   output logic                            rsp_strobe,
   output logic [bbt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bbt_pkg::RIDX_W-1:0]      rsp_result_index,
   output logic [bbt_pkg::RCNT_W-1:0]      rsp_records_in_use,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bbt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bbt_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bbt_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import bbt_pkg::*;

   logic [BYTE_W-1:0] delivery_ff, delivery_in;
   logic [BYTE_W-1:0] retries_ff, retries_in;
   logic              csr_write;
   logic              reg_sel;

   logic    push_valid, queue_full, queue_empty, pop;
   cmd_type push_cmd, queue_cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // Registers sit on 32-bit words; the word index picks one.
   assign reg_sel   = paddr[2];

   always_comb begin
      delivery_in = delivery_ff;
      retries_in  = retries_ff;
      if (csr_write) begin
         unique case (reg_sel)
            CSR_DELIVERY_TICKS: delivery_in = pwdata[BYTE_W-1:0];
            CSR_MAX_RETRIES:    retries_in  = pwdata[BYTE_W-1:0];
            default:            delivery_in = delivery_ff;
         endcase
      end
      unique case (reg_sel)
         CSR_DELIVERY_TICKS: prdata = CSR_DATA_W'(delivery_ff);
         CSR_MAX_RETRIES:    prdata = CSR_DATA_W'(retries_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delivery_ff <= DELIVERY_TICKS_RESET;
         retries_ff  <= MAX_RETRIES_RESET;
      end else begin
         delivery_ff <= delivery_in;
         retries_ff  <= retries_in;
      end
   end

   bbt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_source_address  (req_source_address),
      .req_sequence_number (req_sequence_number),
      .req_entry_index     (req_entry_index),
      .req_all_relayed     (req_all_relayed),
      .req_frame_lost      (req_frame_lost),
      .queue_full          (queue_full),
      .push_valid          (push_valid),
      .push_cmd            (push_cmd)
   );

   bbt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .pop_cmd  (queue_cmd)
   );

   bbt_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (queue_empty),
      .queue_cmd          (queue_cmd),
      .pop                (pop),
      .delivery_ticks     (delivery_ff),
      .max_retries        (retries_ff),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_result_index   (rsp_result_index),
      .rsp_records_in_use (rsp_records_in_use)
   );

endmodule

FILE: sim/broadcast_transaction_table_top_test.sv
// Testbench for broadcast_transaction_table_top: sends find, create, tick and retry words,
// predicts every result from its own copy of the table and checks each one as it arrives.
// Depends on bbt_pkg and the broadcast_transaction_table_top RTL.
`timescale 1ns / 1ps

module broadcast_transaction_table_top_test;
   import bbt_pkg::*;

   localparam int SLOTS = TABLE_ENTRIES;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SRC_W-1:0]  src;
      logic [SEQ_W-1:0]  seq;
      logic [EIDX_W-1:0] slot;
      logic              relayed;
      logic              lost;
   } table_cmd_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [RIDX_W-1:0]   index;
      logic [RCNT_W-1:0]   in_use;
   } table_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [SRC_W-1:0]      req_source_address = '0;
   logic [SEQ_W-1:0]      req_sequence_number = '0;
   logic [EIDX_W-1:0]     req_entry_index = '0;
   logic                  req_all_relayed = 1'b0;
   logic                  req_frame_lost = 1'b0;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [RIDX_W-1:0]     rsp_result_index;
   logic [RCNT_W-1:0]     rsp_records_in_use;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Our own copy of the record table and its two registers.
   logic              slot_used [SLOTS];
   logic [SRC_W-1:0]  slot_src [SLOTS];
   logic [SEQ_W-1:0]  slot_seq [SLOTS];
   logic [BYTE_W-1:0] slot_life [SLOTS];
   logic [BYTE_W-1:0] slot_retries [SLOTS];
   logic              slot_pending [SLOTS];
   int                used_total = 0;
   logic [BYTE_W-1:0] cfg_lifetime = DELIVERY_TICKS_RESET;
   logic [BYTE_W-1:0] cfg_retry_limit = MAX_RETRIES_RESET;

   table_reply_type pending_replies[$];
   int              error_count = 0;
   int              cycle_count = 0;
   bit              no_gaps = 1'b0;

   broadcast_transaction_table_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_source_address(req_source_address),
      .req_sequence_number(req_sequence_number), .req_entry_index(req_entry_index),
      .req_all_relayed(req_all_relayed), .req_frame_lost(req_frame_lost),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_result_index(rsp_result_index), .rsp_records_in_use(rsp_records_in_use),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_replies.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void clear_slot(int i);
      slot_used[i] = 1'b0;
      slot_src[i] = 16'hFFFF;
      slot_seq[i] = '0;
      slot_life[i] = '0;
      slot_retries[i] = '0;
      slot_pending[i] = 1'b0;
   endfunction

   // Applies one word to the table copy and returns the result it must produce.
   function automatic table_reply_type table_apply(table_cmd_type c);
      table_reply_type r;
      bit              done;
      int              i;
      r.status = ST_NONE;
      r.index = '0;
      done = 1'b0;
      case (c.kind)
         KIND_FIND: begin
            r.status = ST_MISS;
            for (i = 0; i < SLOTS; i++) begin
               if (!done && slot_used[i] && slot_src[i] == c.src && slot_seq[i] == c.seq) begin
                  r.status = ST_HIT;
                  r.index = RIDX_W'(i);
                  done = 1'b1;
               end
            end
         end
         KIND_CREATE: begin
            r.status = ST_FULL;
            for (i = 0; i < SLOTS; i++) begin
               if (!done && !slot_used[i]) begin
                  slot_used[i] = 1'b1;
                  slot_src[i] = c.src;
                  slot_seq[i] = c.seq;
                  slot_life[i] = cfg_lifetime;
                  slot_retries[i] = '0;
                  slot_pending[i] = 1'b1;
                  used_total++;
                  r.status = ST_CREATED;
                  r.index = RIDX_W'(i);
                  done = 1'b1;
               end
            end
         end
         KIND_TICK: begin
            if (used_total != 0) begin
               for (i = 0; i < SLOTS; i++) begin
                  if (slot_used[i]) begin
                     if (slot_life[i] != 0) slot_life[i]--;
                     if (slot_life[i] == 0 && !slot_pending[i]) begin
                        clear_slot(i);
                        used_total--;
                     end
                  end
               end
            end
         end
         default: begin
            if (c.slot < SLOTS && slot_used[c.slot]) begin
               if (!slot_pending[c.slot]) begin
                  r.status = ST_RELEASED;
               end else begin
                  slot_retries[c.slot] = slot_retries[c.slot] + 8'd1;
                  if (slot_retries[c.slot] >= cfg_retry_limit || c.relayed || c.lost) begin
                     slot_pending[c.slot] = 1'b0;
                     r.status = ST_RELEASED;
                  end else begin
                     r.status = ST_RETRANSMIT;
                  end
               end
            end
         end
      endcase
      r.in_use = RCNT_W'(used_total);
      return r;
   endfunction

   function automatic table_cmd_type table_cmd(logic [KIND_W-1:0] kind, logic [SRC_W-1:0] src,
                                               logic [SEQ_W-1:0] seq, logic [EIDX_W-1:0] slot,
                                               logic relayed, logic lost);
      table_cmd_type c;
      c.kind = kind;
      c.src = src;
      c.seq = seq;
      c.slot = slot;
      c.relayed = relayed;
      c.lost = lost;
      return c;
   endfunction

   // Mostly well-formed traffic: finds aimed at live keys, creates from a small
   // address pool, retries aimed inside the table, with some noise mixed in.
   function automatic table_cmd_type random_cmd();
      table_cmd_type c;
      int            pick;
      int            base;
      int            k;
      c.kind = KIND_W'($urandom_range(0, 3));
      c.src = SRC_W'($urandom);
      c.seq = SEQ_W'($urandom);
      c.slot = EIDX_W'($urandom);
      c.relayed = 1'($urandom);
      c.lost = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         c.kind = KIND_FIND;
         if (used_total != 0 && $urandom_range(0, 3) != 0) begin
            base = $urandom_range(0, SLOTS - 1);
            for (k = 0; k < SLOTS; k++) begin
               if (slot_used[(base + k) % SLOTS]) begin
                  c.src = slot_src[(base + k) % SLOTS];
                  c.seq = slot_seq[(base + k) % SLOTS];
               end
            end
         end else if ($urandom_range(0, 1) == 0) begin
            c.src[15:4] = 12'hB50;
         end
      end else if (pick < 58) begin
         c.kind = KIND_CREATE;
         if ($urandom_range(0, 3) != 0) c.src[15:4] = 12'hB50;
      end else if (pick < 75) begin
         c.kind = KIND_TICK;
      end else begin
         c.kind = KIND_RETRY;
         if ($urandom_range(0, 9) == 0)
            c.slot = EIDX_W'($urandom_range(SLOTS, 63));
         else
            c.slot = EIDX_W'($urandom_range(0, SLOTS - 1));
         c.relayed = ($urandom_range(0, 5) == 0);
         c.lost = ($urandom_range(0, 5) == 0);
      end
      return c;
   endfunction

   // Sender pause: start drops and the payload carries junk.
   task automatic idle_gap();
      start = 1'b0;
      req_kind = KIND_W'($urandom);
      req_source_address = SRC_W'($urandom);
      req_sequence_number = SEQ_W'($urandom);
      req_entry_index = EIDX_W'($urandom);
      req_all_relayed = 1'($urandom);
      req_frame_lost = 1'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken, or after a random idle gap.
   task automatic send_cmd(table_cmd_type c);
      req_kind = c.kind;
      req_source_address = c.src;
      req_sequence_number = c.seq;
      req_entry_index = c.slot;
      req_all_relayed = c.relayed;
      req_frame_lost = c.lost;
      start = 1'b1;
      do @(posedge clock); while (busy);
      pending_replies.push_back(table_apply(c));
      @(negedge clock);
      if (!no_gaps && $urandom_range(0, 99) < 26) idle_gap();
   endtask

   task automatic wait_idle();
      start = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes one register, then reads it back.
   task automatic write_register(logic reg_sel, logic [BYTE_W-1:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {reg_sel, 2'b00};
      pwdata = {24'($urandom), value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      if (reg_sel == CSR_DELIVERY_TICKS) cfg_lifetime = value;
      else cfg_retry_limit = value;
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {24'd0, value}) begin
         $display("%0t: register %0d read expected %0h actual %0h",
                  $time, reg_sel, value, prdata);
         error_count++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // Four-state compare, so an unknown result bit counts as a mismatch.
   task automatic check_field(string name, logic [RCNT_W-1:0] expected,
                              logic [RCNT_W-1:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected result, status %0d index %0d count %0d",
                     $time, rsp_status, rsp_result_index, rsp_records_in_use);
            error_count++;
         end else begin
            table_reply_type want;
            want = pending_replies.pop_front();
            check_field("status", RCNT_W'(want.status), RCNT_W'(rsp_status));
            check_field("result_index", RCNT_W'(want.index), RCNT_W'(rsp_result_index));
            check_field("records_in_use", want.in_use, rsp_records_in_use);
         end
      end
   end

   // Runs with the reset register values: empty-table cases, duplicate keys,
   // every retry outcome, then enough ticks to expire every released record.
   task automatic test_directed_basics();
      send_cmd(table_cmd(KIND_TICK, 16'h1234, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_FIND, 16'hFFFF, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_RETRY, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_RETRY, 16'hFFFF, 8'hFF, 6'd63, 1'b1, 1'b1));
      send_cmd(table_cmd(KIND_CREATE, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_CREATE, 16'hFFFF, 8'hFF, 6'd63, 1'b1, 1'b1));
      send_cmd(table_cmd(KIND_CREATE, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_FIND, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_FIND, 16'hFFFF, 8'hFF, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_FIND, 16'hFFFF, 8'hFE, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_RETRY, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_RETRY, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_RETRY, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_RETRY, 16'h0000, 8'h00, 6'd1, 1'b1, 1'b0));
      send_cmd(table_cmd(KIND_RETRY, 16'h0000, 8'h00, 6'd2, 1'b0, 1'b1));
      send_cmd(table_cmd(KIND_RETRY, 16'h0000, 8'h00, 6'd16, 1'b0, 1'b0));
      repeat (10) send_cmd(table_cmd(KIND_TICK, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_FIND, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      wait_idle();
   endtask

   // A record born with no lifetime survives ticks only while its
   // transmission is pending.
   task automatic test_zero_lifetime();
      write_register(CSR_DELIVERY_TICKS, 8'd0);
      send_cmd(table_cmd(KIND_CREATE, 16'h0F0F, 8'h5A, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_TICK, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      send_cmd(table_cmd(KIND_RETRY, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b1));
      send_cmd(table_cmd(KIND_TICK, 16'h0000, 8'h00, 6'd0, 1'b0, 1'b0));
      wait_idle();
   endtask

   task automatic test_random_phase(int count, logic [BYTE_W-1:0] lifetime,
                                    logic [BYTE_W-1:0] retry_limit, bit steady);
      write_register(CSR_DELIVERY_TICKS, lifetime);
      write_register(CSR_MAX_RETRIES, retry_limit);
      no_gaps = steady;
      repeat (count) send_cmd(random_cmd());
      no_gaps = 1'b0;
      wait_idle();
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) clear_slot(i);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed_basics();
      test_zero_lifetime();
      test_random_phase(300, DELIVERY_TICKS_RESET, MAX_RETRIES_RESET, 1'b0);
      test_random_phase(300, 8'd255, 8'd255, 1'b1);
      test_random_phase(300, 8'd1, 8'd0, 1'b0);
      test_random_phase(300, 8'd0, 8'd1, 1'b0);
      test_random_phase(300, BYTE_W'($urandom_range(1, 255)), BYTE_W'($urandom), 1'b0);
      test_random_phase(300, 8'd4, 8'd3, 1'b0);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
